// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker of the ARP cache.
// No dependencies; take in by include before use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");

// Clocked check, also active during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

// ----- rtl/arpc_pkg.sv -----
// Shared types and constants of the ARP cache table.
// Used by the controller, datapath and top level.
package arpc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int IP_W = 32;
  localparam int MAC_W = 48;
  localparam int TIME_W = 32;
  localparam int LIFE_W = 23;
  localparam int THR_W = 34;
  localparam int MS_PER_SEC = 1000;

  localparam logic [LIFE_W-1:0] LIFE_RESET = LIFE_W'(300);
  localparam logic [IP_W-1:0] BCAST_IP = '1;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_SWEEP  = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [MAC_W-1:0]  mac;
    logic [IP_W-1:0]   ip;
  } entry_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic commit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_full;
  } stat_t;

endpackage

// ----- rtl/arpc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/arpc_ctrl.sv -----
// Sequencer of the ARP cache: accept, scan, commit, deliver.
// Depends on arpc_pkg.
module arpc_ctrl
  import arpc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  output cmd_t   cmd,
  input  stat_t  stat
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (!stat.out_full) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/arpc_dpath.sv -----
// Datapath of the ARP cache: item registers, entry RAM, valid bits,
// scan accumulators and output register. Depends on arpc_pkg, arpc_ram.
module arpc_dpath
  import arpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  opcode_t           in_op,
  input  logic [IP_W-1:0]   in_ip,
  input  logic [MAC_W-1:0]  in_mac,
  input  logic [TIME_W-1:0] in_now,
  input  logic              cfg_we,
  input  logic [LIFE_W-1:0] cfg_life,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_hit,
  output logic [MAC_W-1:0]  out_mac
);

  opcode_t             op_q;
  logic [IP_W-1:0]     ip_q;
  logic [MAC_W-1:0]    mac_q;
  logic [TIME_W-1:0]   now_q;
  logic [THR_W-1:0]    thr;
  logic [LIFE_W-1:0]   life;

  logic [ENTRIES-1:0]  valid;
  logic [IDX_W-1:0]    scan_idx;
  logic                proc_valid;
  logic [IDX_W-1:0]    proc_idx;

  logic                found;
  logic [MAC_W-1:0]    found_mac;
  logic                free_found;
  logic [TIME_W-1:0]   oldest;
  logic [IDX_W-1:0]    slot;

  logic [$bits(entry_t)-1:0] rd_word;
  entry_t              rd_entry;
  entry_t              wr_entry;
  logic [TIME_W-1:0]   age;
  logic                over;
  logic                ent_valid;
  logic                bcast;

  assign rd_entry  = entry_t'(rd_word);
  assign wr_entry  = '{stamp: now_q, mac: mac_q, ip: ip_q};
  assign age       = now_q - rd_entry.stamp;
  assign over      = {(THR_W-TIME_W)'(0), age} >= thr;
  assign ent_valid = valid[proc_idx];
  assign bcast     = (ip_q == BCAST_IP);

  assign stat.scan_last = (scan_idx == IDX_W'(ENTRIES-1));
  assign stat.out_full  = out_valid && !out_ready;

  arpc_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.commit && (op_q == OP_INSERT)),
    .waddr(slot),
    .wdata(wr_entry),
    .re   (cmd.rd_en),
    .raddr(scan_idx),
    .rdata(rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      life <= LIFE_RESET;
    end else if (cfg_we) begin
      life <= cfg_life;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= in_op;
      ip_q  <= in_ip;
      mac_q <= in_mac;
      now_q <= in_now;
      thr   <= (THR_W'(life) + THR_W'(1)) * THR_W'(MS_PER_SEC);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      proc_valid <= 1'b0;
      proc_idx   <= '0;
    end else begin
      if (cmd.load) begin
        scan_idx <= '0;
      end else if (cmd.rd_en) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
      proc_valid <= cmd.rd_en;
      proc_idx   <= scan_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      found      <= 1'b0;
      found_mac  <= '0;
      free_found <= 1'b0;
      oldest     <= '0;
      slot       <= '0;
    end else if (proc_valid) begin
      if (!found && ent_valid && (rd_entry.ip == ip_q)) begin
        found     <= 1'b1;
        found_mac <= rd_entry.mac;
      end
      if (!free_found) begin
        if (!ent_valid) begin
          free_found <= 1'b1;
          slot       <= proc_idx;
        end else if (age >= oldest) begin
          oldest <= age;
          slot   <= proc_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (cmd.commit && (op_q == OP_CLEAR)) begin
        valid <= '0;
      end else if (cmd.commit && (op_q == OP_INSERT)) begin
        valid[slot] <= 1'b1;
      end
      if (proc_valid && (op_q == OP_SWEEP) && ent_valid && over) begin
        valid[proc_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_hit <= (op_q == OP_LOOKUP) && (bcast || found);
      if (op_q != OP_LOOKUP) begin
        out_mac <= '0;
      end else if (bcast) begin
        out_mac <= '1;
      end else begin
        out_mac <= found_mac;
      end
    end
  end

endmodule

// ----- rtl/arp_cache_table.sv -----
// Channel      Dir  Payload
// s_axis       in   tuser: opcode; tdata: ip_addr, mac_addr, now_ms
// m_axis       out  tuser: hit; tdata: mac_out
// cfg          in   cfg_data: life_seconds
//
// Items are taken one at a time: one read of the entry RAM per slot, then
// drain, commit and result load, which waits while the output is stalled.
// A finished result waits in the output register while the next item is
// taken. Reset clears all valid bits, the lifetime (to 300 s) and the output
// valid flag; stored entries stay undefined until written.
module arp_cache_table
  import arpc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,   // ip_addr[31:0], mac_addr[79:32], now_ms[111:80]
  input  logic [1:0]   s_axis_tuser,   // opcode[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [47:0]  m_axis_tdata,   // mac_out[47:0]
  output logic         m_axis_tuser,   // hit[0]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [22:0]  cfg_data        // life_seconds[22:0]
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  arpc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .cmd     (cmd),
    .stat    (stat)
  );

  arpc_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_op    (opcode_t'(s_axis_tuser)),
    .in_ip    (s_axis_tdata[31:0]),
    .in_mac   (s_axis_tdata[79:32]),
    .in_now   (s_axis_tdata[111:80]),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_life (cfg_data),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_hit  (m_axis_tuser),
    .out_mac  (m_axis_tdata)
  );

endmodule

// ----- rtl/arpc_checker.sv -----
// Port-level checks of the ARP cache table, bound to the top level.
// Depends on assert_macros.svh and arp_cache_table.
`include "assert_macros.svh"

module arpc_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [47:0]  m_axis_tdata,
  input logic         m_axis_tuser
);

  // hold a stalled result
  `ASSERT_CLK(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // a miss carries a zero MAC
  `ASSERT_CLK(a_miss_zero, clk, rst, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 48'd0)

  // one item at a time: no acceptance right after a transaction
  `ASSERT_CLK(a_one_item, clk, rst, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

  // reset empties the output
  `ASSERT_ALWAYS(a_rst_out, clk, rst |=> !m_axis_tvalid)

endmodule

bind arp_cache_table arpc_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
